[src/dft_pkg.sv]
`timescale 1ns / 1ps

package dft_pkg;

  // Widths fixed by the item and register fields.
  localparam int MODE_W     = 2;
  localparam int CH_W       = 3;
  localparam int THR_W      = 11;
  localparam int FRAME_W    = 16;
  localparam int PINS       = 8;
  localparam int SPEED_W    = 2;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int BIT_IDX_W  = 4;

  // Tick counter covers the longest period: the default bit period at the x4 scale.
  localparam int TICK_W     = 8;
  localparam int PERIOD_W   = TICK_W + 1;

  // Parameter defaults.
  localparam int CHANNELS_DEF        = 8;
  localparam int BIT_TICKS_DEF       = 27;
  localparam int ZERO_HIGH_TICKS_DEF = 10;
  localparam int ONE_HIGH_TICKS_DEF  = 20;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_START = 2'd2;

  // Speed codes.
  localparam logic [SPEED_W-1:0] SPEED_X2 = 2'd1;
  localparam logic [SPEED_W-1:0] SPEED_X4 = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'b1;

  localparam logic [BIT_IDX_W-1:0] LAST_BIT = 4'd15;

  // Nonzero throttle values below this are commands and carry the flag bit.
  localparam logic [THR_W-1:0] CMD_THR_LIMIT = 11'd24;

  typedef struct packed {
    logic                 sending;
    logic [BIT_IDX_W-1:0] bit_index;
    logic [TICK_W-1:0]    tick_count;
  } tx_state_t;

  function automatic logic [1:0] speed_shift(input logic [SPEED_W-1:0] code);
    logic [1:0] sh;
    case (code)
      SPEED_X2: sh = 2'd1;
      SPEED_X4: sh = 2'd2;
      default:  sh = 2'd0;
    endcase
    return sh;
  endfunction

  function automatic logic [FRAME_W-1:0] build_frame(input logic [THR_W-1:0] thr);
    logic [11:0] v;
    logic [3:0]  csum;
    v    = {thr, (thr != '0) && (thr < CMD_THR_LIMIT)};
    csum = v[3:0] ^ v[7:4] ^ v[11:8];
    return {v, csum};
  endfunction

endpackage

[src/dft_frame_store.sv]
`timescale 1ns / 1ps

module dft_frame_store
  import dft_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [CH_W-1:0]                    wr_channel,
  input  logic [FRAME_W-1:0]                 wr_frame,
  input  logic                               start,
  output logic [CHANNELS-1:0][FRAME_W-1:0]   sending_nxt
);

  logic [CHANNELS-1:0][FRAME_W-1:0] channel_frames_r;
  logic [CHANNELS-1:0][FRAME_W-1:0] sending_frames_r;

  // The frames in flight are swapped in at the frame start only.
  assign sending_nxt = start ? channel_frames_r : sending_frames_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_frames_r <= '0;
      sending_frames_r <= '0;
    end else begin
      sending_frames_r <= sending_nxt;
      for (int c = 0; c < CHANNELS; c++) begin
        if (wr_en && ({1'b0, wr_channel} == (CH_W + 1)'(c))) begin
          channel_frames_r[c] <= wr_frame;
        end
      end
    end
  end

endmodule

[src/dft_bit_timer.sv]
`timescale 1ns / 1ps

module dft_bit_timer
  import dft_pkg::*;
#(
  parameter int BIT_TICKS = BIT_TICKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [MODE_W-1:0]  mode,
  input  logic [SPEED_W-1:0] speed_mode,
  output tx_state_t          st_nxt,
  output logic               start,
  output logic               done
);

  tx_state_t           st_r;
  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W-1:0] tick_inc;

  assign period   = PERIOD_W'(BIT_TICKS) << speed_shift(speed_mode);
  assign tick_inc = {1'b0, st_r.tick_count} + PERIOD_W'(1);
  assign start    = accept && (mode == MODE_START) && !st_r.sending;

  always_comb begin
    st_nxt = st_r;
    done   = 1'b0;
    if (start) begin
      st_nxt.sending    = 1'b1;
      st_nxt.bit_index  = '0;
      st_nxt.tick_count = '0;
    end else if (accept && (mode == MODE_TICK) && st_r.sending) begin
      // A period shortened by a speed change mid-bit ends on this tick.
      if (tick_inc >= period) begin
        st_nxt.tick_count = '0;
        if (st_r.bit_index == LAST_BIT) begin
          st_nxt.bit_index = '0;
          st_nxt.sending   = 1'b0;
          done             = 1'b1;
        end else begin
          st_nxt.bit_index = st_r.bit_index + BIT_IDX_W'(1);
        end
      end else begin
        st_nxt.tick_count = tick_inc[TICK_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  a_end_on_last_bit: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(st_r.sending) |-> ($past(st_r.bit_index) == LAST_BIT))
    else $error("transmission ended before the last bit");

  a_start_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(st_r.sending) |-> (st_r.bit_index == '0) && (st_r.tick_count == '0))
    else $error("transmission started off the first tick");

  a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.sending |-> (st_r.bit_index == '0))
    else $error("bit index moved while idle");

endmodule

[src/dshot_frame_transmitter_top.sv]
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// in_       in_valid / in_stall    in_mode, in_channel, in_throttle
// out_      out_valid / out_stall  out_pin_levels, out_busy_res, out_frame_word,
//                                  out_frame_done
// cfg_      cfg_we                 cfg_index, cfg_data
//
// Each transaction updates state at the accepting edge and the result is in the
// output register on the next cycle, so one item per cycle is sustained while the
// output is not stalled. The output register holds one result; in_stall is raised only while
// it is full and out_stall is high. Synchronous reset clears all frames, the bit
// timer, the configuration registers and the output valid.

module dshot_frame_transmitter_top
  import dft_pkg::*;
#(
  parameter int CHANNELS        = CHANNELS_DEF,
  parameter int BIT_TICKS       = BIT_TICKS_DEF,
  parameter int ZERO_HIGH_TICKS = ZERO_HIGH_TICKS_DEF,
  parameter int ONE_HIGH_TICKS  = ONE_HIGH_TICKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [CH_W-1:0]       in_channel,
  input  logic [THR_W-1:0]      in_throttle,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PINS-1:0]       out_pin_levels,
  output logic                  out_busy_res,
  output logic [FRAME_W-1:0]    out_frame_word,
  output logic                  out_frame_done,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [SPEED_W-1:0]               speed_mode_r;
  logic [PINS-1:0]                  channel_enable_r;
  logic                             accept;
  logic                             wr_en;
  logic [FRAME_W-1:0]               frame;
  logic                             start;
  logic                             done;
  tx_state_t                        st_nxt;
  logic [CHANNELS-1:0][FRAME_W-1:0] sending_nxt;
  logic [1:0]                       sh;
  logic [PINS-1:0]                  levels;

  logic                             out_valid_r;
  logic [PINS-1:0]                  pin_levels_r;
  logic                             busy_r;
  logic [FRAME_W-1:0]               frame_word_r;
  logic                             frame_done_r;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign wr_en    = accept && (in_mode == MODE_WRITE);
  assign frame    = build_frame(in_throttle);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_mode_r     <= '0;
      channel_enable_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPEED:  speed_mode_r     <= cfg_data[SPEED_W-1:0];
        CFG_ENABLE: channel_enable_r <= cfg_data[PINS-1:0];
        default: ;
      endcase
    end
  end

  dft_frame_store #(
    .CHANNELS(CHANNELS)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (wr_en),
    .wr_channel (in_channel),
    .wr_frame   (frame),
    .start      (start),
    .sending_nxt(sending_nxt)
  );

  dft_bit_timer #(
    .BIT_TICKS(BIT_TICKS)
  ) u_timer (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .mode      (in_mode),
    .speed_mode(speed_mode_r),
    .st_nxt    (st_nxt),
    .start     (start),
    .done      (done)
  );

  // Pin levels after this item, from the next timer state and frames.
  assign sh = speed_shift(speed_mode_r);

  always_comb begin
    logic                bit_val;
    logic [PERIOD_W-1:0] hi;
    levels = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      bit_val = sending_nxt[c][LAST_BIT - st_nxt.bit_index];
      hi = (bit_val ? PERIOD_W'(ONE_HIGH_TICKS) : PERIOD_W'(ZERO_HIGH_TICKS)) << sh;
      levels[c] = st_nxt.sending && channel_enable_r[c] &&
                  ({1'b0, st_nxt.tick_count} < hi);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pin_levels_r <= levels;
      busy_r       <= st_nxt.sending;
      frame_word_r <= (in_mode == MODE_WRITE) ? frame : '0;
      frame_done_r <= done;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pin_levels = pin_levels_r;
  assign out_busy_res   = busy_r;
  assign out_frame_word = frame_word_r;
  assign out_frame_done = frame_done_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done) |-> !out_busy_res)
    else $error("frame_done reported while still busy");

  a_idle_pins_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_busy_res) |-> (out_pin_levels == '0))
    else $error("pins driven while idle");

  a_frame_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_frame_word[3:0] ^ out_frame_word[7:4] ^ out_frame_word[11:8]
                    ^ out_frame_word[15:12]) == 4'd0))
    else $error("frame check nibble does not match");

endmodule

[sim/tb_dshot_frame_transmitter_top.sv]
`timescale 1ns / 1ps

module tb_dshot_frame_transmitter_top;
  import dft_pkg::*;

  // Mode and speed codes that the package leaves unnamed.
  localparam logic [MODE_W-1:0]  MODE_SPARE = 2'd3;
  localparam logic [SPEED_W-1:0] SPEED_X1   = 2'd0;
  localparam logic [SPEED_W-1:0] SPEED_BAD  = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CH_W-1:0]   channel;
    logic [THR_W-1:0]  throttle;
  } dshot_item_t;

  typedef struct packed {
    logic [PINS-1:0]    pins;
    logic               busy;
    logic [FRAME_W-1:0] word;
    logic               done;
  } dshot_res_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [MODE_W-1:0]     in_mode = '0;
  logic [CH_W-1:0]       in_channel = '0;
  logic [THR_W-1:0]      in_throttle = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PINS-1:0]       out_pin_levels;
  logic                  out_busy_res;
  logic [FRAME_W-1:0]    out_frame_word;
  logic                  out_frame_done;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  dshot_frame_transmitter_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_channel     (in_channel),
    .in_throttle    (in_throttle),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pin_levels (out_pin_levels),
    .out_busy_res   (out_busy_res),
    .out_frame_word (out_frame_word),
    .out_frame_done (out_frame_done),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Transmitter state as the testbench sees it.
  logic [FRAME_W-1:0] stored_frame [CHANNELS_DEF] = '{default: '0};
  logic [FRAME_W-1:0] latched_frame [CHANNELS_DEF] = '{default: '0};
  int                 cur_bit = 0;
  int                 cur_tick = 0;
  logic               tx_active = 1'b0;
  logic [SPEED_W-1:0] speed_reg = '0;
  logic [PINS-1:0]    enable_reg = '0;

  dshot_item_t pending_items[$];
  dshot_res_t  predicted_results[$];
  dshot_item_t offered_item;
  dshot_res_t  want_res;

  int  fail_count = 0;
  int  accepted_count = 0;
  int  result_count = 0;
  int  frames_done = 0;
  int  send_gap = 0;
  int  stall_gap = 0;
  int  hold_left = 0;
  int  hold_requests = 0;
  int  holds_served = 0;
  bit  quiet = 1'b0;

  function automatic int tick_scale(input logic [SPEED_W-1:0] code);
    case (code)
      SPEED_X2: return 2;
      SPEED_X4: return 4;
      default:  return 1;
    endcase
  endfunction

  function automatic logic [FRAME_W-1:0] encode_frame(input logic [THR_W-1:0] thr);
    logic [11:0] data;
    data[11:1] = thr;
    data[0]    = (thr >= 1) && (thr <= 23);
    return {data, data[11:8] ^ data[7:4] ^ data[3:0]};
  endfunction

  function automatic dshot_res_t dshot_step(input dshot_item_t it);
    dshot_res_t r;
    int         scale;
    int         high_len;
    logic       bit_val;
    r     = '0;
    scale = tick_scale(speed_reg);
    case (it.mode)
      MODE_TICK: begin
        if (tx_active) begin
          cur_tick++;
          if (cur_tick >= BIT_TICKS_DEF * scale) begin
            cur_tick = 0;
            if (cur_bit >= LAST_BIT) begin
              cur_bit   = 0;
              tx_active = 1'b0;
              r.done    = 1'b1;
            end else begin
              cur_bit++;
            end
          end
        end
      end
      MODE_WRITE: begin
        r.word = encode_frame(it.throttle);
        if (it.channel < CHANNELS_DEF) stored_frame[it.channel] = r.word;
      end
      MODE_START: begin
        if (!tx_active) begin
          latched_frame = stored_frame;
          cur_bit       = 0;
          cur_tick      = 0;
          tx_active     = 1'b1;
        end
      end
      default: ;
    endcase
    if (tx_active) begin
      for (int c = 0; c < CHANNELS_DEF; c++) begin
        if (enable_reg[c]) begin
          bit_val  = latched_frame[c][FRAME_W-1-cur_bit];
          high_len = (bit_val ? ONE_HIGH_TICKS_DEF : ZERO_HIGH_TICKS_DEF) * scale;
          if (cur_tick < high_len) r.pins[c] = 1'b1;
        end
      end
    end
    r.busy = tx_active;
    return r;
  endfunction

  function automatic logic [THR_W-1:0] pick_throttle();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return THR_W'($urandom_range(1, 23));
      2:       return THR_W'(24);
      3:       return '1;
      default: return THR_W'($urandom_range(0, 2047));
    endcase
  endfunction

  // Sender: offers queued items, holds a stalled item steady.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_results.push_back(dshot_step(offered_item));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && pending_items.size() != 0 && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          offered_item = pending_items.pop_front();
          in_valid    <= 1'b1;
          in_mode     <= offered_item.mode;
          in_channel  <= offered_item.channel;
          in_throttle <= offered_item.throttle;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transaction and applies back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        result_count++;
        if (predicted_results.size() == 0) begin
          $error("result transaction with no prediction waiting");
          fail_count++;
        end else begin
          want_res = predicted_results.pop_front();
          if (out_pin_levels !== want_res.pins) begin
            $error("pin_levels: expected %02h, actual %02h", want_res.pins, out_pin_levels);
            fail_count++;
          end
          if (out_busy_res !== want_res.busy) begin
            $error("busy_res: expected %0d, actual %0d", want_res.busy, out_busy_res);
            fail_count++;
          end
          if (out_frame_word !== want_res.word) begin
            $error("frame_word: expected %04h, actual %04h", want_res.word, out_frame_word);
            fail_count++;
          end
          if (out_frame_done !== want_res.done) begin
            $error("frame_done: expected %0d, actual %0d", want_res.done, out_frame_done);
            fail_count++;
          end
          if (want_res.done) frames_done++;
        end
      end
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = 60;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else if (stall_gap > 0) begin
        stall_gap--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        stall_gap = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic queue_item(input logic [MODE_W-1:0] mode, input logic [CH_W-1:0] ch,
                            input logic [THR_W-1:0] thr);
    dshot_item_t it;
    it.mode     = mode;
    it.channel  = ch;
    it.throttle = thr;
    pending_items.push_back(it);
  endtask

  // Ticks carry random channel and throttle bits, which the block must ignore; other items are mixed in at random.
  task automatic queue_ticks(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        case ($urandom_range(0, 2))
          0:       queue_item(MODE_WRITE, CH_W'($urandom), pick_throttle());
          1:       queue_item(MODE_START, CH_W'($urandom), THR_W'($urandom));
          default: queue_item(MODE_SPARE, CH_W'($urandom), THR_W'($urandom));
        endcase
      end
      queue_item(MODE_TICK, CH_W'($urandom), THR_W'($urandom));
    end
  endtask

  task automatic queue_frame(input int n_writes, input int n_ticks);
    for (int i = 0; i < n_writes; i++) begin
      queue_item(MODE_WRITE, CH_W'($urandom_range(0, 7)), pick_throttle());
    end
    queue_item(MODE_START, CH_W'($urandom), THR_W'($urandom));
    queue_ticks(n_ticks);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_items.size() != 0 || predicted_results.size() != 0 || in_valid) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SPEED) speed_reg = val[SPEED_W-1:0];
    else enable_reg = val[PINS-1:0];
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    write_reg(CFG_SPEED, CFG_DATA_W'(SPEED_X1));
    write_reg(CFG_ENABLE, 8'h00);

    // Directed: idle items, frame encodings at the edges, start while busy.
    queue_item(MODE_TICK, 3'd7, 11'h7ff);
    queue_item(MODE_SPARE, 3'd0, 11'h000);
    queue_item(MODE_WRITE, 3'd0, 11'd0);
    queue_item(MODE_WRITE, 3'd1, 11'd1);
    queue_item(MODE_WRITE, 3'd2, 11'd23);
    queue_item(MODE_WRITE, 3'd3, 11'd24);
    queue_item(MODE_WRITE, 3'd4, 11'd2047);
    queue_item(MODE_WRITE, 3'd5, 11'd48);
    queue_item(MODE_WRITE, 3'd6, 11'd1024);
    queue_item(MODE_WRITE, 3'd7, 11'h555);
    queue_item(MODE_START, 3'd0, 11'd0);
    queue_item(MODE_START, 3'd7, 11'h7ff);
    queue_item(MODE_TICK, 3'd0, 11'd0);
    queue_item(MODE_TICK, 3'd0, 11'd0);
    queue_item(MODE_WRITE, 3'd3, 11'h2aa);
    queue_item(MODE_SPARE, 3'd7, 11'h7ff);
    queue_item(MODE_TICK, 3'd5, 11'h3c3);
    wait_drained();

    // The frame is still in flight: switch to all pins at the slowest rate.
    write_reg(CFG_ENABLE, 8'hff);
    write_reg(CFG_SPEED, CFG_DATA_W'(SPEED_X4));
    hold_requests++;
    queue_frame(5, 150);
    wait_drained();

    // Dropping to x1 mid-bit ends the current bit on the next tick.
    write_reg(CFG_SPEED, CFG_DATA_W'(SPEED_X1));
    write_reg(CFG_ENABLE, CFG_DATA_W'($urandom_range(0, 255)));
    queue_ticks(400);
    wait_drained();

    write_reg(CFG_SPEED, CFG_DATA_W'(SPEED_X2));
    write_reg(CFG_ENABLE, CFG_DATA_W'($urandom_range(0, 255)));
    queue_frame(8, 150);
    wait_drained();

    quiet = 1'b1;
    write_reg(CFG_SPEED, CFG_DATA_W'(SPEED_BAD));
    write_reg(CFG_ENABLE, 8'hff);
    queue_ticks(400);
    wait_drained();
    repeat (4) @(posedge clk);

    $display("Checked %0d results for %0d transactions, %0d frames sent to completion.",
             result_count, accepted_count, frames_done);
    $display("Covered all speed codes, enable masks from none to all, mid-frame changes.");
    if (fail_count == 0) begin
      $display("tb_dshot_frame_transmitter_top: PASS");
    end else begin
      $display("tb_dshot_frame_transmitter_top: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_dshot_frame_transmitter_top: FAIL");
    $finish;
  end

endmodule

[dshot_frame_transmitter_top.f]
src/dft_pkg.sv
src/dft_frame_store.sv
src/dft_bit_timer.sv
src/dshot_frame_transmitter_top.sv
sim/tb_dshot_frame_transmitter_top.sv
